>>> rtl/second_shortest_path_engine_defines.svh
// Assertion macros for the second shortest path engine
`ifndef SECOND_SHORTEST_PATH_ENGINE_DEFINES_SVH
`define SECOND_SHORTEST_PATH_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SSPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SSPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sspe_pkg.sv
// Types and constants shared by the second shortest path engine
`timescale 1ns / 1ps
package sspe_pkg;

    localparam int NODE_W      = 10;
    localparam int WEIGHT_W    = 16;
    localparam int DIST_W      = 31;
    localparam int LINK_W      = 14;
    localparam int DEG_W       = 14;
    localparam int EDGE_AW     = 13;
    localparam int QUEUE_AW    = 14;
    localparam int COUNT_W     = 15;
    localparam int NODE_DEPTH  = 1024;
    localparam int EDGE_DEPTH  = 8192;
    localparam int QUEUE_DEPTH = 16384;

    localparam logic [DIST_W-1:0] DIST_INF   = 31'h7FFF_FFFF;
    localparam logic [LINK_W-1:0] LINK_EMPTY = 14'h2000;

    localparam logic       CMD_ADD = 1'b0;
    localparam logic       CMD_RUN = 1'b1;

    localparam logic       CFG_NODE_COUNT = 1'b0;
    localparam logic       CFG_MIN_DEGREE = 1'b1;

    localparam logic [1:0] ST_FOUND      = 2'd0;
    localparam logic [1:0] ST_NO_PATH    = 2'd1;
    localparam logic [1:0] ST_QUEUE_OVF  = 2'd2;
    localparam logic [1:0] ST_STORE_FULL = 2'd3;

    typedef struct packed {
        logic                command;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] weight;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DIST_W-1:0] distance;
    } out_t;

    typedef struct packed {
        logic [LINK_W-1:0] head;
        logic [DEG_W-1:0]  degree;
    } node_word_t;

    typedef struct packed {
        logic [NODE_W-1:0]   target;
        logic [WEIGHT_W-1:0] length;
        logic [LINK_W-1:0]   link;
    } edge_word_t;

    typedef struct packed {
        logic [DIST_W-1:0] cost;
        logic [NODE_W-1:0] node;
    } heap_word_t;

    typedef struct packed {
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] second;
    } dist_word_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node_raddr;
        logic               node_we;
        logic [NODE_W-1:0]  node_waddr;
        node_word_t         node_wdata;
        logic [EDGE_AW-1:0] edge_raddr;
        logic               edge_we;
        logic [EDGE_AW-1:0] edge_waddr;
        edge_word_t         edge_wdata;
    } graph_req_t;

    typedef struct packed {
        node_word_t node_word;
        edge_word_t edge_word;
    } graph_rsp_t;

    typedef struct packed {
        logic [QUEUE_AW-1:0] heap_raddr_a;
        logic [QUEUE_AW-1:0] heap_raddr_b;
        logic                heap_we;
        logic [QUEUE_AW-1:0] heap_waddr;
        heap_word_t          heap_wdata;
        logic [NODE_W-1:0]   dist_raddr;
        logic                dist_we;
        logic [NODE_W-1:0]   dist_waddr;
        dist_word_t          dist_wdata;
    } queue_req_t;

    typedef struct packed {
        heap_word_t heap_a;
        heap_word_t heap_b;
        dist_word_t node_dist;
    } queue_rsp_t;

endpackage

>>> rtl/second_shortest_path_engine.sv
// Edge add: a fitting add passes S_A1, S_A2 and S_A3 before ready returns, so
// the next add waits for it. Run: data dependent; a heap pop passes S_POP,
// S_POP1 and an S_SD0/S_SD1 pair per sift level, an edge S_EDGE to S_E3, and
// a push an S_PU0/S_PU1 pair per level. After each run and reset a sweep clears
// all node heads, degrees and distances; no transaction is accepted meanwhile.
// Configuration is held. Reset is asynchronous and active low.
`timescale 1ns / 1ps
module second_shortest_path_engine
    import sspe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [DEG_W-1:0] cfg_wdata
);

    graph_req_t greq;
    graph_rsp_t grsp;
    queue_req_t qreq;
    queue_rsp_t qrsp;

    sspe_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .greq      (greq),
        .grsp      (grsp),
        .qreq      (qreq),
        .qrsp      (qrsp)
    );

    sspe_graph u_graph (
        .clk (clk),
        .req (greq),
        .rsp (grsp)
    );

    sspe_queue u_queue (
        .clk (clk),
        .req (qreq),
        .rsp (qrsp)
    );

endmodule

>>> rtl/sspe_graph.sv
// Adjacency store: per-node head and degree, directed edge entries
`timescale 1ns / 1ps
module sspe_graph
    import sspe_pkg::*;
(
    input  logic       clk,
    input  graph_req_t req,
    output graph_rsp_t rsp
);

    node_word_t node_mem [NODE_DEPTH];
    edge_word_t edge_mem [EDGE_DEPTH];
    node_word_t node_rdata_reg;
    edge_word_t edge_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.node_we)
        begin
            node_mem[req.node_waddr] <= req.node_wdata;
        end
        node_rdata_reg <= node_mem[req.node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req.edge_we)
        begin
            edge_mem[req.edge_waddr] <= req.edge_wdata;
        end
        edge_rdata_reg <= edge_mem[req.edge_raddr];
    end

    assign rsp.node_word = node_rdata_reg;
    assign rsp.edge_word = edge_rdata_reg;

endmodule

>>> rtl/sspe_queue.sv
// Binary heap store and per-node best and second distances
`timescale 1ns / 1ps
module sspe_queue
    import sspe_pkg::*;
(
    input  logic       clk,
    input  queue_req_t req,
    output queue_rsp_t rsp
);

    heap_word_t heap_mem [QUEUE_DEPTH];
    dist_word_t dist_mem [NODE_DEPTH];
    heap_word_t heap_a_reg;
    heap_word_t heap_b_reg;
    dist_word_t dist_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.heap_we)
        begin
            heap_mem[req.heap_waddr] <= req.heap_wdata;
        end
        heap_a_reg <= heap_mem[req.heap_raddr_a];
        heap_b_reg <= heap_mem[req.heap_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (req.dist_we)
        begin
            dist_mem[req.dist_waddr] <= req.dist_wdata;
        end
        dist_rdata_reg <= dist_mem[req.dist_raddr];
    end

    assign rsp.heap_a    = heap_a_reg;
    assign rsp.heap_b    = heap_b_reg;
    assign rsp.node_dist = dist_rdata_reg;

endmodule

>>> rtl/sspe_seq.sv
// Sequencer: edge loading, heap search, result register and clearing sweep
`timescale 1ns / 1ps
module sspe_seq
    import sspe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_t              out_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [DEG_W-1:0]  cfg_wdata,
    output graph_req_t        greq,
    input  graph_rsp_t        grsp,
    output queue_req_t        qreq,
    input  queue_rsp_t        qrsp
);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_A1    = 5'd2;
    localparam logic [4:0] S_A2    = 5'd3;
    localparam logic [4:0] S_A3    = 5'd4;
    localparam logic [4:0] S_R0    = 5'd5;
    localparam logic [4:0] S_POP   = 5'd6;
    localparam logic [4:0] S_POP1  = 5'd7;
    localparam logic [4:0] S_SD0   = 5'd8;
    localparam logic [4:0] S_SD1   = 5'd9;
    localparam logic [4:0] S_CHK1  = 5'd10;
    localparam logic [4:0] S_HEAD  = 5'd11;
    localparam logic [4:0] S_EDGE  = 5'd12;
    localparam logic [4:0] S_E1    = 5'd13;
    localparam logic [4:0] S_E2    = 5'd14;
    localparam logic [4:0] S_E3    = 5'd15;
    localparam logic [4:0] S_PU0   = 5'd16;
    localparam logic [4:0] S_PU1   = 5'd17;
    localparam logic [4:0] S_FIN   = 5'd18;
    localparam logic [4:0] S_EMIT  = 5'd19;

    logic [4:0]          state_reg, state_next;
    logic [NODE_W-1:0]   node_count_reg, node_count_next;
    logic [DEG_W-1:0]    min_degree_reg, min_degree_next;
    logic [LINK_W-1:0]   fill_reg, fill_next;
    logic                full_reg, full_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [NODE_W-1:0]   sweep_reg, sweep_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_data_reg, out_data_next;
    out_t                res_reg, res_next;
    logic [NODE_W-1:0]   a_reg, a_next;
    logic [NODE_W-1:0]   b_reg, b_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic [DIST_W-1:0]   d_reg, d_next;
    logic [NODE_W-1:0]   u_reg, u_next;
    heap_word_t          x_reg, x_next;
    logic [QUEUE_AW-1:0] i_reg, i_next;
    logic [LINK_W-1:0]   e_reg, e_next;
    logic [NODE_W-1:0]   v_reg, v_next;
    logic [DIST_W-1:0]   nd_reg, nd_next;

    logic [LINK_W-1:0]   fill_p1;
    logic [COUNT_W-1:0]  count_m1;
    logic [COUNT_W-1:0]  left_idx;
    logic [COUNT_W:0]    right_idx;
    logic                take_l, take_r;
    logic [DIST_W-1:0]   small_d;
    logic [QUEUE_AW-1:0] i_m1;
    logic [QUEUE_AW-1:0] parent_idx;
    logic [DIST_W:0]     sum;
    logic [DIST_W-1:0]   nd_sat;

    always_comb
    begin
        fill_p1    = fill_reg + LINK_W'(1);
        count_m1   = count_reg - COUNT_W'(1);
        left_idx   = {i_reg, 1'b1};
        right_idx  = {1'b0, i_reg, 1'b0} + (COUNT_W + 1)'(2);
        take_l     = (left_idx < count_reg) && (qrsp.heap_a.cost < x_reg.cost);
        small_d    = take_l ? qrsp.heap_a.cost : x_reg.cost;
        take_r     = (right_idx < {1'b0, count_reg}) && (qrsp.heap_b.cost < small_d);
        i_m1       = i_reg - QUEUE_AW'(1);
        parent_idx = {1'b0, i_m1[QUEUE_AW-1:1]};
        sum        = {1'b0, d_reg} + (DIST_W + 1)'(grsp.edge_word.length);
        nd_sat     = (sum > {1'b0, DIST_INF}) ? DIST_INF : sum[DIST_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        min_degree_next = min_degree_reg;
        fill_next       = fill_reg;
        full_next       = full_reg;
        count_next      = count_reg;
        sweep_next      = sweep_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        res_next        = res_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        w_next          = w_reg;
        d_next          = d_reg;
        u_next          = u_reg;
        x_next          = x_reg;
        i_next          = i_reg;
        e_next          = e_reg;
        v_next          = v_reg;
        nd_next         = nd_reg;
        greq            = '0;
        qreq            = '0;
        in_ready        = (state_reg == S_IDLE);

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_NODE_COUNT: node_count_next = cfg_wdata[NODE_W-1:0];
                CFG_MIN_DEGREE: min_degree_next = cfg_wdata;
                default:        ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                greq.node_we            = 1'b1;
                greq.node_waddr         = sweep_reg;
                greq.node_wdata.head    = LINK_EMPTY;
                greq.node_wdata.degree  = '0;
                qreq.dist_we            = 1'b1;
                qreq.dist_waddr         = sweep_reg;
                qreq.dist_wdata.best    = DIST_INF;
                qreq.dist_wdata.second  = DIST_INF;
                sweep_next              = sweep_reg + NODE_W'(1);
                if (sweep_reg == NODE_W'(NODE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                greq.node_raddr = in_data.node_a;
                if (in_valid)
                begin
                    a_next = in_data.node_a;
                    b_next = in_data.node_b;
                    w_next = in_data.weight;
                    if (in_data.command == CMD_ADD)
                    begin
                        if (({1'b0, fill_reg} + (LINK_W + 1)'(2)) > (LINK_W + 1)'(EDGE_DEPTH))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_A1;
                        end
                    end
                    else if (full_reg)
                    begin
                        res_next   = '{status: ST_STORE_FULL, distance: '0};
                        state_next = S_EMIT;
                    end
                    else if (node_count_reg == '0)
                    begin
                        res_next   = '{status: ST_NO_PATH, distance: '0};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_R0;
                    end
                end
            end
            S_A1:
            begin
                greq.edge_we           = 1'b1;
                greq.edge_waddr        = fill_reg[EDGE_AW-1:0];
                greq.edge_wdata.target = b_reg;
                greq.edge_wdata.length = w_reg;
                greq.edge_wdata.link   = grsp.node_word.head;
                greq.node_we           = 1'b1;
                greq.node_waddr        = a_reg;
                greq.node_wdata.head   = fill_reg;
                greq.node_wdata.degree = grsp.node_word.degree + DEG_W'(1);
                state_next             = S_A2;
            end
            S_A2:
            begin
                greq.node_raddr = b_reg;
                state_next      = S_A3;
            end
            S_A3:
            begin
                greq.edge_we           = 1'b1;
                greq.edge_waddr        = fill_p1[EDGE_AW-1:0];
                greq.edge_wdata.target = a_reg;
                greq.edge_wdata.length = w_reg;
                greq.edge_wdata.link   = grsp.node_word.head;
                greq.node_we           = 1'b1;
                greq.node_waddr        = b_reg;
                greq.node_wdata.head   = fill_p1;
                greq.node_wdata.degree = grsp.node_word.degree + DEG_W'(1);
                fill_next              = fill_reg + LINK_W'(2);
                state_next             = S_IDLE;
            end
            S_R0:
            begin
                qreq.dist_we           = 1'b1;
                qreq.dist_waddr        = NODE_W'(1);
                qreq.dist_wdata.best   = '0;
                qreq.dist_wdata.second = DIST_INF;
                qreq.heap_we           = 1'b1;
                qreq.heap_waddr        = '0;
                qreq.heap_wdata.cost   = '0;
                qreq.heap_wdata.node   = NODE_W'(1);
                count_next             = COUNT_W'(1);
                state_next             = S_POP;
            end
            S_POP:
            begin
                if (count_reg == '0)
                begin
                    qreq.dist_raddr = node_count_reg;
                    state_next      = S_FIN;
                end
                else
                begin
                    qreq.heap_raddr_a = '0;
                    qreq.heap_raddr_b = count_m1[QUEUE_AW-1:0];
                    count_next        = count_m1;
                    state_next        = S_POP1;
                end
            end
            S_POP1:
            begin
                d_next     = qrsp.heap_a.cost;
                u_next     = qrsp.heap_a.node;
                x_next     = qrsp.heap_b;
                i_next     = '0;
                state_next = S_SD0;
            end
            S_SD0:
            begin
                qreq.heap_raddr_a = left_idx[QUEUE_AW-1:0];
                qreq.heap_raddr_b = right_idx[QUEUE_AW-1:0];
                state_next        = S_SD1;
            end
            S_SD1:
            begin
                qreq.heap_we    = 1'b1;
                qreq.heap_waddr = i_reg;
                if (take_r)
                begin
                    qreq.heap_wdata = qrsp.heap_b;
                    i_next          = right_idx[QUEUE_AW-1:0];
                    state_next      = S_SD0;
                end
                else if (take_l)
                begin
                    qreq.heap_wdata = qrsp.heap_a;
                    i_next          = left_idx[QUEUE_AW-1:0];
                    state_next      = S_SD0;
                end
                else
                begin
                    qreq.heap_wdata = x_reg;
                    qreq.dist_raddr = u_reg;
                    state_next      = S_CHK1;
                end
            end
            S_CHK1:
            begin
                if (d_reg > qrsp.node_dist.second)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    greq.node_raddr = u_reg;
                    state_next      = S_HEAD;
                end
            end
            S_HEAD:
            begin
                e_next     = grsp.node_word.head;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                if (e_reg >= LINK_W'(EDGE_DEPTH))
                begin
                    state_next = S_POP;
                end
                else
                begin
                    greq.edge_raddr = e_reg[EDGE_AW-1:0];
                    state_next      = S_E1;
                end
            end
            S_E1:
            begin
                v_next  = grsp.edge_word.target;
                e_next  = grsp.edge_word.link;
                nd_next = nd_sat;
                if ((grsp.edge_word.target == '0) ||
                    (grsp.edge_word.target > node_count_reg))
                begin
                    state_next = S_EDGE;
                end
                else
                begin
                    greq.node_raddr = grsp.edge_word.target;
                    state_next      = S_E2;
                end
            end
            S_E2:
            begin
                if ((grsp.node_word.degree < min_degree_reg) &&
                    (v_reg != NODE_W'(1)) && (v_reg != node_count_reg))
                begin
                    state_next = S_EDGE;
                end
                else
                begin
                    qreq.dist_raddr = v_reg;
                    state_next      = S_E3;
                end
            end
            S_E3:
            begin
                state_next = S_EDGE;
                if ((qrsp.node_dist.best > nd_reg) ||
                    ((nd_reg < qrsp.node_dist.second) && (nd_reg > qrsp.node_dist.best)))
                begin
                    qreq.dist_we    = 1'b1;
                    qreq.dist_waddr = v_reg;
                    if (qrsp.node_dist.best > nd_reg)
                    begin
                        qreq.dist_wdata.best   = nd_reg;
                        qreq.dist_wdata.second = qrsp.node_dist.best;
                    end
                    else
                    begin
                        qreq.dist_wdata.best   = qrsp.node_dist.best;
                        qreq.dist_wdata.second = nd_reg;
                    end
                    if (count_reg >= COUNT_W'(QUEUE_DEPTH))
                    begin
                        res_next   = '{status: ST_QUEUE_OVF, distance: '0};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        i_next     = count_reg[QUEUE_AW-1:0];
                        count_next = count_reg + COUNT_W'(1);
                        state_next = S_PU0;
                    end
                end
            end
            S_PU0:
            begin
                if (i_reg == '0)
                begin
                    qreq.heap_we         = 1'b1;
                    qreq.heap_waddr      = '0;
                    qreq.heap_wdata.cost = nd_reg;
                    qreq.heap_wdata.node = v_reg;
                    state_next           = S_EDGE;
                end
                else
                begin
                    qreq.heap_raddr_a = parent_idx;
                    state_next        = S_PU1;
                end
            end
            S_PU1:
            begin
                qreq.heap_we    = 1'b1;
                qreq.heap_waddr = i_reg;
                if (nd_reg < qrsp.heap_a.cost)
                begin
                    qreq.heap_wdata = qrsp.heap_a;
                    i_next          = parent_idx;
                    state_next      = S_PU0;
                end
                else
                begin
                    qreq.heap_wdata.cost = nd_reg;
                    qreq.heap_wdata.node = v_reg;
                    state_next           = S_EDGE;
                end
            end
            S_FIN:
            begin
                if (qrsp.node_dist.second == DIST_INF)
                begin
                    res_next = '{status: ST_NO_PATH, distance: '0};
                end
                else
                begin
                    res_next = '{status: ST_FOUND, distance: qrsp.node_dist.second};
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    fill_next      = '0;
                    full_next      = 1'b0;
                    count_next     = '0;
                    sweep_next     = '0;
                    state_next     = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                sweep_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            node_count_reg <= NODE_W'(2);
            min_degree_reg <= '0;
            fill_reg       <= '0;
            full_reg       <= 1'b0;
            count_reg      <= '0;
            sweep_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            min_degree_reg <= min_degree_next;
            fill_reg       <= fill_next;
            full_reg       <= full_next;
            count_reg      <= count_next;
            sweep_reg      <= sweep_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        res_reg      <= res_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        w_reg        <= w_next;
        d_reg        <= d_next;
        u_reg        <= u_next;
        x_reg        <= x_next;
        i_reg        <= i_next;
        e_reg        <= e_next;
        v_reg        <= v_next;
        nd_reg       <= nd_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/sspe_checker.sv
// Port-level checks for the second shortest path engine, bound to the top level
`timescale 1ns / 1ps
`include "second_shortest_path_engine_defines.svh"
module sspe_checker
    import sspe_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    `SSPE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
    `SSPE_ASSERT_NEXT(a_run_busy, clk, rst_n, in_valid && in_ready && (in_data.command == CMD_RUN), !in_ready, "ready straight after a run transaction")
    `SSPE_ASSERT_NEXT(a_one_result, clk, rst_n, out_valid && out_ready, !out_valid, "second result directly after a taken one")
    `SSPE_ASSERT_NOW(a_zero_dist, clk, rst_n, out_valid && (out_data.status != ST_FOUND), out_data.distance == '0, "distance not zero without a path")

endmodule

bind second_shortest_path_engine sspe_checker u_sspe_checker (.*);
